>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked implication checks with a reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/cse_pkg.sv
// ---------------------------------------------------------------------------
// cse_pkg
// Types and constants shared by the chunk stream section extractor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cse_pkg;

    // Width of the stream offset counter and of the offset registers.
    localparam int OFF_W       = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int STREAM_W    = 2;
    localparam int PAYLOAD_W   = 7;
    localparam int LEN_FIELD_W = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_SELECT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECTION_START  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECTION_LENGTH = 2'd2;

    // Mask that picks the stream number out of a chunk header.
    localparam logic [7:0] STREAM_MASK = 8'b0000_0011;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_file;
    } cse_in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       section_end;
        logic       incomplete;
    } cse_out_t;

endpackage

>>> rtl/core/cse_front.sv
// ---------------------------------------------------------------------------
// cse_front
// Parses chunk headers, counts selected-stream bytes and classifies each
// accepted byte against the section window.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [cse_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cse_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cse_pkg::cse_in_t                    s_data,
    output logic                                push,
    output cse_pkg::cse_out_t                   push_data,
    input  logic                                queue_full
);
    import cse_pkg::*;

    logic [STREAM_W-1:0]  stream_sel_reg;
    logic [OFF_W-1:0]     start_reg;
    logic [OFF_W-1:0]     len_m1_reg;
    logic                 len_zero_reg;
    logic [OFF_W-1:0]     cfg_value;

    logic                 expect_header_reg, expect_header_next;
    logic [PAYLOAD_W-1:0] payload_left_reg, payload_left_next;
    logic                 chunk_sel_reg, chunk_sel_next;
    logic [OFF_W-1:0]     offset_reg, offset_next;

    logic                 accept;
    logic                 is_header;
    logic [OFF_W:0]       diff;
    logic [OFF_W-1:0]     rel;
    logic                 at_or_past_start;
    logic                 off_not_full;
    logic                 in_window;
    logic                 is_last;
    logic                 pass_byte;
    logic                 count_byte;
    logic                 complete_hold;
    logic                 complete_inc;
    logic                 complete;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    // Configuration writes; the length is kept as length minus one plus a zero flag.
    assign cfg_value = OFF_W'(cfg_wr_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_sel_reg <= '0;
            start_reg      <= '0;
            len_m1_reg     <= '0;
            len_zero_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STREAM_SELECT: begin
                    stream_sel_reg <= STREAM_W'(cfg_wr_data[7:0] & STREAM_MASK);
                end
                CFG_SECTION_START: begin
                    start_reg <= cfg_value;
                end
                CFG_SECTION_LENGTH: begin
                    len_m1_reg   <= cfg_value - OFF_W'(1);
                    len_zero_reg <= (cfg_value == '0);
                end
                default: begin
                end
            endcase
        end
    end

    // Window compare on the offset relative to the section start.
    assign is_header        = expect_header_reg || (payload_left_reg == '0);
    assign diff             = {1'b0, offset_reg} - {1'b0, start_reg};
    assign rel              = diff[OFF_W-1:0];
    assign at_or_past_start = !diff[OFF_W];
    assign off_not_full     = (offset_reg != '1);
    assign in_window        = off_not_full && at_or_past_start && !len_zero_reg
                              && (rel <= len_m1_reg);
    assign is_last          = in_window && (rel == len_m1_reg);
    assign count_byte       = !is_header && chunk_sel_reg && off_not_full;
    assign pass_byte        = !is_header && chunk_sel_reg && in_window;

    // Completeness after this byte, worked out from the old relative offset.
    assign complete_hold = at_or_past_start && (len_zero_reg || (rel > len_m1_reg));
    assign complete_inc  = ((diff == '1) && len_zero_reg)
                           || (at_or_past_start && (len_zero_reg || (rel >= len_m1_reg)));
    assign complete      = count_byte ? complete_inc : complete_hold;

    // Next parser state for an accepted byte.
    always_comb begin
        expect_header_next = expect_header_reg;
        payload_left_next  = payload_left_reg;
        chunk_sel_next     = chunk_sel_reg;
        offset_next        = offset_reg;
        if (is_header) begin
            payload_left_next  = PAYLOAD_W'(s_data.byte_value[7:2]) + PAYLOAD_W'(1);
            chunk_sel_next     = (STREAM_W'(s_data.byte_value & STREAM_MASK)
                                  == stream_sel_reg);
            expect_header_next = 1'b0;
        end else begin
            if (count_byte) begin
                offset_next = offset_reg + OFF_W'(1);
            end
            payload_left_next  = payload_left_reg - PAYLOAD_W'(1);
            expect_header_next = (payload_left_reg == PAYLOAD_W'(1));
        end
        if (s_data.end_of_file) begin
            expect_header_next = 1'b1;
            payload_left_next  = '0;
            chunk_sel_next     = 1'b0;
            offset_next        = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg <= 1'b1;
            payload_left_reg  <= '0;
            chunk_sel_reg     <= 1'b0;
            offset_reg        <= '0;
        end else if (accept) begin
            expect_header_reg <= expect_header_next;
            payload_left_reg  <= payload_left_next;
            chunk_sel_reg     <= chunk_sel_next;
            offset_reg        <= offset_next;
        end
    end

    // A result leaves for a passed byte or for the end-of-file byte.
    assign push                  = accept && (pass_byte || s_data.end_of_file);
    assign push_data.data_byte   = pass_byte ? s_data.byte_value : 8'd0;
    assign push_data.data_valid  = pass_byte;
    assign push_data.section_end = pass_byte && is_last;
    assign push_data.incomplete  = s_data.end_of_file && !complete;

endmodule

>>> rtl/core/cse_queue.sv
// ---------------------------------------------------------------------------
// cse_queue
// Short result queue that decouples the parser from the output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cse_pkg::cse_out_t push_data,
    output logic              full,
    input  logic              pop,
    output cse_pkg::cse_out_t pop_data,
    output logic              empty
);
    import cse_pkg::*;

    cse_out_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push, do_pop;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/core/cse_back.sv
// ---------------------------------------------------------------------------
// cse_back
// Output register stage: drains the result queue onto the result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              queue_empty,
    input  cse_pkg::cse_out_t queue_data,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output cse_pkg::cse_out_t m_data
);
    import cse_pkg::*;

    logic     m_valid_reg;
    cse_out_t m_data_reg;

    // Load a new result whenever the output register is empty or being drained.
    assign pop = !queue_empty && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= queue_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/core/chunk_stream_section_extract.sv
// ---------------------------------------------------------------------------
// chunk_stream_section_extract
// Extracts a byte section of one stream from a chunked container file.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid, s_ready, s_data) takes one container byte per
//   transfer together with an end-of-file flag. The result channel (m_valid,
//   m_ready, m_data) delivers one transfer for every passed section byte and
//   one for the end-of-file byte, which carries the incomplete flag.
//   Bytes that are headers or lie outside the section produce no transfer.
//   The configuration port (cfg_wr_en, cfg_index, cfg_wr_data) sets the stream,
//   section start and section length; write it only while the block is idle.
//   Throughput is one byte per cycle while s_ready is high; the window compare
//   in the front parser is combinational. The result of an accepted byte is
//   written into the queue at the accepting edge and then moves into the
//   output register, which drives m_valid, once that register is free.
//   When the receiver stalls, the output register holds, the two-entry queue
//   fills, and s_ready drops until space frees up. Reset clears the parser,
//   the queue and the output register at once and restores the register
//   defaults (stream 0, start 0, length 1); no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chunk_stream_section_extract (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [cse_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cse_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cse_pkg::cse_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cse_pkg::cse_out_t                   m_data
);
    import cse_pkg::*;

    logic     push;
    cse_out_t push_data;
    logic     queue_full;
    logic     queue_empty;
    logic     pop;
    cse_out_t pop_data;

    // Parser and classifier.
    cse_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .push        (push),
        .push_data   (push_data),
        .queue_full  (queue_full)
    );

    // Result queue between the parser and the output stage.
    cse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    // Output register stage.
    cse_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .queue_data  (pop_data),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

>>> rtl/core/cse_checker.sv
// ---------------------------------------------------------------------------
// cse_checker
// Port-level checks on the result channel of the section extractor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cse_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input cse_pkg::cse_out_t m_data
);
    import cse_pkg::*;

    // A stalled result holds its value until it is taken.
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // The section end mark only rides on a passed byte.
    `ASSERT_IMPLIES(a_end_has_byte, aclk, aresetn, m_valid && m_data.section_end, m_data.data_valid)

    // A transfer without a section byte carries a zero byte.
    `ASSERT_IMPLIES(a_zero_byte, aclk, aresetn, m_valid && !m_data.data_valid, m_data.data_byte == 8'd0)

    // Once the last section byte passes, the section cannot be incomplete.
    `ASSERT_IMPLIES(a_end_complete, aclk, aresetn, m_valid && m_data.section_end, !m_data.incomplete)

endmodule

bind chunk_stream_section_extract cse_checker u_cse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
